/* hdl/bqc_pkg.sv */
package bqc_pkg;

   localparam int SAMPLE_WIDTH = 24;
   localparam int COEFF_WIDTH  = 32;
   // Q8.24 coefficients
   localparam int COEFF_FRAC   = COEFF_WIDTH - 8;
   localparam int STATE_WIDTH  = 48;
   localparam int NUM_COEFFS   = 5;

   localparam logic [1:0] ACT_FILTER = 2'd0;
   localparam logic [1:0] ACT_WRITE  = 2'd1;
   localparam logic [1:0] ACT_CLEAR  = 2'd2;

   localparam logic [2:0] COEF_B0 = 3'd0;
   localparam logic [2:0] COEF_B1 = 3'd1;
   localparam logic [2:0] COEF_B2 = 3'd2;
   localparam logic [2:0] COEF_A1 = 3'd3;
   localparam logic [2:0] COEF_A2 = 3'd4;

   typedef struct packed {
      logic [1:0]                     action;
      logic signed [SAMPLE_WIDTH-1:0] sample_in;
      logic [1:0]                     section_index;
      logic [2:0]                     coeff_index;
      logic signed [COEFF_WIDTH-1:0]  coeff_value;
   } req_type;

   typedef struct packed {
      logic signed [SAMPLE_WIDTH-1:0] sample_out;
      logic                           overflow;
   } rsp_type;

endpackage

/* hdl/biquad_cascade_iir_filter.sv */
// Cascade of up to MAX_SECTIONS direct-form-II biquads (Q1.23 samples, Q8.24
// coefficients, 48-bit state). A filter request is loaded and then runs each
// section in use in turn on the single shared multiplier, which makes two
// 32x25 passes for each of the five products of a section, with b0*w waiting
// for the saturated w. A finished sample also waits in its last step while
// the previous response is still stalled.
// req_stall stays high while a sample is in flight. Coefficient write and
// clear requests take effect when accepted and give no response. The user
// must write sections_in_use through the csr port only while the block is
// idle; the block itself does not enforce this. 0 acts as 1.
module biquad_cascade_iir_filter #(
   parameter int MAX_SECTIONS = 4
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  bqc_pkg::req_type  req,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output bqc_pkg::rsp_type  rsp,
   input  logic              csr_valid,
   output logic              csr_ready,
   input  logic [2:0]        csr_data
);

   localparam int SEC_W  = (MAX_SECTIONS > 1) ? $clog2(MAX_SECTIONS) : 1;
   localparam int SW     = bqc_pkg::SAMPLE_WIDTH;
   localparam int CW     = bqc_pkg::COEFF_WIDTH;
   localparam int STW    = bqc_pkg::STATE_WIDTH;
   localparam int HALF_W = STW / 2;
   localparam int OPB_W  = HALF_W + 1;
   localparam int MUL_W  = CW + OPB_W;
   localparam int FULL_W = CW + STW;
   localparam int RND_W  = FULL_W - bqc_pkg::COEFF_FRAC;
   localparam int ACC_W  = RND_W + 2;

   // step codes within one section
   localparam logic [3:0] ST_FIRST_ACC  = 4'd3;
   localparam logic [3:0] ST_W_ACC_LAST = 4'd5;
   localparam logic [3:0] ST_W_SAT      = 4'd6;
   localparam logic [3:0] ST_Y_ACC_LAST = 4'd11;
   localparam logic [3:0] ST_END        = 4'd12;

   localparam logic signed [FULL_W-1:0] RND_HALF =
      FULL_W'(1) <<< (bqc_pkg::COEFF_FRAC - 1);

   logic                     busy_ff, busy_in;
   logic [3:0]               st_ff, st_in;
   logic [SEC_W-1:0]         sec_ff, sec_in;
   logic [SEC_W-1:0]         last_ff, last_in;
   logic signed [ACC_W-1:0]  wacc_ff, wacc_in;
   logic signed [ACC_W-1:0]  yacc_ff, yacc_in;
   logic signed [STW-1:0]    w_ff, w_in;
   logic                     ovf_ff, ovf_in;
   logic signed [MUL_W-1:0]  mul_ff, mul_in;
   logic signed [MUL_W-1:0]  hi_ff, hi_in;
   logic signed [FULL_W-1:0] full_ff, full_in;
   logic [2:0]               nsec_ff, nsec_in;
   logic                     rsp_valid_ff, rsp_valid_in;
   bqc_pkg::rsp_type         rsp_ff, rsp_in;
   logic signed [CW-1:0]     coef_ff [MAX_SECTIONS][bqc_pkg::NUM_COEFFS];
   logic signed [CW-1:0]     coef_in [MAX_SECTIONS][bqc_pkg::NUM_COEFFS];
   logic signed [STW-1:0]    delay_ff [MAX_SECTIONS][2];
   logic signed [STW-1:0]    delay_in [MAX_SECTIONS][2];

   logic [2:0]               cidx;
   logic signed [STW-1:0]    opval;
   logic signed [CW-1:0]     opa;
   logic signed [OPB_W-1:0]  opb;
   logic signed [RND_W-1:0]  rnd;
   logic [SEC_W+1:0]         wsec;

   function automatic logic fits_state(input logic signed [ACC_W-1:0] v);
      return (&v[ACC_W-1:STW-1]) || !(|v[ACC_W-1:STW-1]);
   endfunction

   function automatic logic signed [STW-1:0] sat_state(input logic signed [ACC_W-1:0] v);
      if (fits_state(v)) begin
         return v[STW-1:0];
      end
      return v[ACC_W-1] ? {1'b1, {(STW-1){1'b0}}} : {1'b0, {(STW-1){1'b1}}};
   endfunction

   function automatic logic fits_sample(input logic signed [ACC_W-1:0] v);
      return (&v[ACC_W-1:SW-1]) || !(|v[ACC_W-1:SW-1]);
   endfunction

   function automatic logic signed [SW-1:0] sat_sample(input logic signed [ACC_W-1:0] v);
      if (fits_sample(v)) begin
         return v[SW-1:0];
      end
      return v[ACC_W-1] ? {1'b1, {(SW-1){1'b0}}} : {1'b0, {(SW-1){1'b1}}};
   endfunction

   // multiplier operands: two passes per product, high half then low half
   always_comb begin
      case (st_ff[3:1])
         3'd0: begin
            cidx  = bqc_pkg::COEF_A1;
            opval = delay_ff[sec_ff][0];
         end
         3'd1: begin
            cidx  = bqc_pkg::COEF_A2;
            opval = delay_ff[sec_ff][1];
         end
         3'd2: begin
            cidx  = bqc_pkg::COEF_B1;
            opval = delay_ff[sec_ff][0];
         end
         3'd3: begin
            cidx  = bqc_pkg::COEF_B2;
            opval = delay_ff[sec_ff][1];
         end
         default: begin
            cidx  = bqc_pkg::COEF_B0;
            opval = w_ff;
         end
      endcase
      opa = coef_ff[sec_ff][cidx];
      opb = st_ff[0] ? $signed({1'b0, opval[HALF_W-1:0]})
                     : $signed({opval[STW-1], opval[STW-1:HALF_W]});
   end

   assign rnd  = full_ff[FULL_W-1:bqc_pkg::COEFF_FRAC];
   assign wsec = (SEC_W+2)'(req.section_index);

   always_comb begin
      busy_in      = busy_ff;
      st_in        = st_ff;
      sec_in       = sec_ff;
      last_in      = last_ff;
      wacc_in      = wacc_ff;
      yacc_in      = yacc_ff;
      w_in         = w_ff;
      ovf_in       = ovf_ff;
      nsec_in      = nsec_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_in       = rsp_ff;
      coef_in      = coef_ff;
      delay_in     = delay_ff;

      mul_in  = MUL_W'(opa) * MUL_W'(opb);
      hi_in   = mul_ff;
      full_in = (FULL_W'(hi_ff) <<< HALF_W) + FULL_W'(mul_ff) + RND_HALF;

      if (csr_valid) begin
         nsec_in = csr_data;
      end
      if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end

      if (!busy_ff) begin
         if (req_valid) begin
            case (req.action)
               bqc_pkg::ACT_FILTER: begin
                  busy_in = 1'b1;
                  st_in   = '0;
                  sec_in  = '0;
                  wacc_in = ACC_W'(req.sample_in);
                  yacc_in = '0;
                  ovf_in  = 1'b0;
                  if (nsec_ff == 3'd0) begin
                     last_in = '0;
                  end else if (int'(nsec_ff) > MAX_SECTIONS) begin
                     last_in = SEC_W'(MAX_SECTIONS - 1);
                  end else begin
                     last_in = SEC_W'(nsec_ff - 3'd1);
                  end
               end
               bqc_pkg::ACT_WRITE: begin
                  if ((int'(wsec) < MAX_SECTIONS) &&
                      (int'(req.coeff_index) < bqc_pkg::NUM_COEFFS)) begin
                     coef_in[wsec[SEC_W-1:0]][req.coeff_index] = req.coeff_value;
                  end
               end
               bqc_pkg::ACT_CLEAR: begin
                  for (int i = 0; i < MAX_SECTIONS; i++) begin
                     delay_in[i][0] = '0;
                     delay_in[i][1] = '0;
                  end
               end
               default: begin
               end
            endcase
         end
      end else begin
         // rounded product is accumulated once its high pass has gone through mul_ff, hi_ff and full_ff
         if (st_ff[0] && st_ff >= ST_FIRST_ACC && st_ff <= ST_Y_ACC_LAST) begin
            if (st_ff <= ST_W_ACC_LAST) begin
               wacc_in = wacc_ff + ACC_W'(rnd);
            end else begin
               yacc_in = yacc_ff + ACC_W'(rnd);
            end
         end
         if (st_ff == ST_W_SAT) begin
            w_in   = sat_state(wacc_ff);
            ovf_in = ovf_ff | !fits_state(wacc_ff);
         end
         if (st_ff == ST_END) begin
            if (sec_ff == last_ff) begin
               // hold here until the output register is free
               if (!rsp_valid_ff || !rsp_stall) begin
                  delay_in[sec_ff][1] = delay_ff[sec_ff][0];
                  delay_in[sec_ff][0] = w_ff;
                  rsp_in.sample_out   = sat_sample(yacc_ff);
                  rsp_in.overflow     = ovf_ff | !fits_sample(yacc_ff);
                  rsp_valid_in        = 1'b1;
                  busy_in             = 1'b0;
               end
            end else begin
               delay_in[sec_ff][1] = delay_ff[sec_ff][0];
               delay_in[sec_ff][0] = w_ff;
               wacc_in = ACC_W'(sat_state(yacc_ff));
               yacc_in = '0;
               ovf_in  = ovf_ff | !fits_state(yacc_ff);
               sec_in  = sec_ff + 1'b1;
               st_in   = '0;
            end
         end else begin
            st_in = st_ff + 4'd1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff      <= 1'b0;
         st_ff        <= '0;
         sec_ff       <= '0;
         nsec_ff      <= 3'd1;
         rsp_valid_ff <= 1'b0;
         for (int i = 0; i < MAX_SECTIONS; i++) begin
            for (int j = 0; j < bqc_pkg::NUM_COEFFS; j++) begin
               coef_ff[i][j] <= '0;
            end
            delay_ff[i][0] <= '0;
            delay_ff[i][1] <= '0;
         end
      end else begin
         busy_ff      <= busy_in;
         st_ff        <= st_in;
         sec_ff       <= sec_in;
         nsec_ff      <= nsec_in;
         rsp_valid_ff <= rsp_valid_in;
         coef_ff      <= coef_in;
         delay_ff     <= delay_in;
      end
   end

   always_ff @(posedge clock) begin
      last_ff <= last_in;
      wacc_ff <= wacc_in;
      yacc_ff <= yacc_in;
      w_ff    <= w_in;
      ovf_ff  <= ovf_in;
      mul_ff  <= mul_in;
      hi_ff   <= hi_in;
      full_ff <= full_in;
      rsp_ff  <= rsp_in;
   end

   assign req_stall = busy_ff;
   assign rsp_valid = rsp_valid_ff;
   assign rsp       = rsp_ff;
   assign csr_ready = 1'b1;

endmodule

/* dv/tb.sv */
module tb;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int N_SEC = 4;
   localparam int SW = bqc_pkg::SAMPLE_WIDTH;
   localparam int DRAIN_CYCLES = 120;
   localparam int unsigned CYCLE_LIMIT = 2_000_000;

   localparam logic [1:0] ACT_UNUSED  = 2'd3;
   localparam logic [2:0] COEF_BAD_LO = 3'd5;
   localparam logic [2:0] COEF_BAD_HI = 3'd7;

   localparam logic signed [bqc_pkg::SAMPLE_WIDTH-1:0] SMP_MAX = 24'sh7FFFFF;
   localparam logic signed [bqc_pkg::SAMPLE_WIDTH-1:0] SMP_MIN = 24'sh800000;
   localparam logic signed [bqc_pkg::COEFF_WIDTH-1:0]  CF_ONE  = 32'sh0100_0000;
   localparam logic signed [bqc_pkg::COEFF_WIDTH-1:0]  CF_MAX  = 32'sh7FFF_FFFF;
   localparam logic signed [bqc_pkg::COEFF_WIDTH-1:0]  CF_MIN  = 32'sh8000_0000;

   typedef enum {STALL_NONE, STALL_COIN, STALL_HEAVY, STALL_PERIODIC} stall_mode_type;

   class biquad_checker_type;
      logic [2:0]                             sections;
      logic signed [bqc_pkg::COEFF_WIDTH-1:0] coef [N_SEC][bqc_pkg::NUM_COEFFS];
      logic signed [bqc_pkg::STATE_WIDTH-1:0] delay_line [2*N_SEC];
      bqc_pkg::rsp_type                       expected_out [$];
      bit                                     sat_hit;
      int                                     errors;

      function new();
         sections = 3'd1;
         errors = 0;
         foreach (coef[s, k]) coef[s][k] = '0;
         foreach (delay_line[i]) delay_line[i] = '0;
      endfunction

      function void set_sections(logic [2:0] v);
         sections = v;
      endfunction

      function int pending();
         return expected_out.size();
      endfunction

      // exact (c * s + half LSB) >>> COEFF_FRAC
      function logic signed [63:0] mul_rnd(logic signed [bqc_pkg::COEFF_WIDTH-1:0] c,
                                           logic signed [bqc_pkg::STATE_WIDTH-1:0] s);
         logic signed [79:0] p;
         p = 80'(c) * 80'(s);
         p = p + (80'sd1 <<< (bqc_pkg::COEFF_FRAC - 1));
         p = p >>> bqc_pkg::COEFF_FRAC;
         return p[63:0];
      endfunction

      function logic signed [63:0] clamp(logic signed [63:0] v, int width);
         logic signed [63:0] hi;
         logic signed [63:0] lo;
         hi = (64'sd1 <<< (width - 1)) - 64'sd1;
         lo = -(64'sd1 <<< (width - 1));
         if (v > hi) begin
            sat_hit = 1'b1;
            return hi;
         end
         if (v < lo) begin
            sat_hit = 1'b1;
            return lo;
         end
         return v;
      endfunction

      function bqc_pkg::rsp_type run_cascade(logic signed [bqc_pkg::SAMPLE_WIDTH-1:0] smp);
         bqc_pkg::rsp_type                       res;
         logic signed [63:0]                     x;
         logic signed [63:0]                     w;
         logic signed [63:0]                     y;
         logic signed [bqc_pkg::STATE_WIDTH-1:0] s0;
         logic signed [bqc_pkg::STATE_WIDTH-1:0] s1;
         int                                     n;
         n = int'(sections);
         if (n < 1) n = 1;
         if (n > N_SEC) n = N_SEC;
         sat_hit = 1'b0;
         x = 64'(smp);
         for (int k = 0; k < n; k++) begin
            s0 = delay_line[2*k];
            s1 = delay_line[2*k+1];
            w = x + mul_rnd(coef[k][bqc_pkg::COEF_A1], s0)
                + mul_rnd(coef[k][bqc_pkg::COEF_A2], s1);
            w = clamp(w, bqc_pkg::STATE_WIDTH);
            y = mul_rnd(coef[k][bqc_pkg::COEF_B0], w[bqc_pkg::STATE_WIDTH-1:0])
                + mul_rnd(coef[k][bqc_pkg::COEF_B1], s0)
                + mul_rnd(coef[k][bqc_pkg::COEF_B2], s1);
            y = clamp(y, bqc_pkg::STATE_WIDTH);
            delay_line[2*k+1] = s0;
            delay_line[2*k]   = w[bqc_pkg::STATE_WIDTH-1:0];
            x = y;
         end
         x = clamp(x, bqc_pkg::SAMPLE_WIDTH);
         res.sample_out = x[bqc_pkg::SAMPLE_WIDTH-1:0];
         res.overflow   = sat_hit;
         return res;
      endfunction

      function void note_request(bqc_pkg::req_type r);
         case (r.action)
            bqc_pkg::ACT_WRITE: begin
               if (r.coeff_index <= bqc_pkg::COEF_A2 && r.section_index < N_SEC)
                  coef[r.section_index][r.coeff_index] = r.coeff_value;
            end
            bqc_pkg::ACT_CLEAR: begin
               foreach (delay_line[i]) delay_line[i] = '0;
            end
            bqc_pkg::ACT_FILTER: begin
               expected_out.push_back(run_cascade(r.sample_in));
            end
            default: ;
         endcase
      endfunction

      task report(string what);
         errors++;
         if (errors <= 40) $display("MISMATCH at %0t: %s", $realtime, what);
      endtask

      task check_response(bqc_pkg::rsp_type got);
         bqc_pkg::rsp_type e;
         if (expected_out.size() == 0) begin
            report($sformatf("unexpected response sample_out=%0d overflow=%0b",
                             got.sample_out, got.overflow));
         end else begin
            e = expected_out.pop_front();
            if (got.sample_out !== e.sample_out)
               report($sformatf("sample_out got %0d want %0d", got.sample_out,
                                e.sample_out));
            if (got.overflow !== e.overflow)
               report($sformatf("overflow got %0b want %0b (sample_out %0d)",
                                got.overflow, e.overflow, e.sample_out));
         end
      endtask

      task finish_check();
         if (expected_out.size() != 0)
            report($sformatf("%0d responses never arrived", expected_out.size()));
      endtask
   endclass

   logic             clock;
   logic             reset = 1'b1;
   logic             req_valid = 1'b0;
   logic             req_stall;
   bqc_pkg::req_type req = '0;
   logic             rsp_valid;
   logic             rsp_stall = 1'b0;
   bqc_pkg::rsp_type rsp;
   logic             csr_valid = 1'b0;
   logic             csr_ready;
   logic [2:0]       csr_data = 3'd0;

   biquad_checker_type sb = new();

   int             burst_left = 0;
   stall_mode_type stall_mode = STALL_NONE;
   int             stall_left = 0;
   int unsigned    cycles = 0;
   int             phase_sec [9] = '{4, 7, 0, 2, 3, 5, 6, 1, 4};

   biquad_cascade_iir_filter #(
      .MAX_SECTIONS(N_SEC)
   ) i_dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req       (req),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp       (rsp),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_data  (csr_data)
   );

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   always @(posedge clock) begin
      cycles++;
      if (cycles > CYCLE_LIMIT) begin
         $display("** biquad_cascade_iir_filter: FAILED **");
         $finish;
      end
   end

   // receiver back-pressure, switching among four patterns after a random run
   always @(posedge clock) begin
      if (stall_left == 0) begin
         stall_mode = stall_mode_type'($urandom_range(0, 3));
         stall_left = $urandom_range(30, 300);
      end else begin
         stall_left--;
      end
      case (stall_mode)
         STALL_NONE:  rsp_stall <= 1'b0;
         STALL_COIN:  rsp_stall <= ($urandom_range(0, 1) == 1);
         STALL_HEAVY: rsp_stall <= ($urandom_range(0, 3) != 0);
         default:     rsp_stall <= ((stall_left % 16) < 5);
      endcase
   end

   always @(posedge clock) begin
      if (!reset) begin
         if (req_valid && !req_stall) sb.note_request(req);
         if (rsp_valid && !rsp_stall) sb.check_response(rsp);
         if (csr_valid && csr_ready) sb.set_sections(csr_data);
      end
   end

   function automatic bqc_pkg::req_type mk(logic [1:0] act,
                                           logic signed [bqc_pkg::SAMPLE_WIDTH-1:0] smp,
                                           logic [1:0] sec, logic [2:0] ci,
                                           logic signed [bqc_pkg::COEFF_WIDTH-1:0] val);
      bqc_pkg::req_type r;
      r.action        = act;
      r.sample_in     = smp;
      r.section_index = sec;
      r.coeff_index   = ci;
      r.coeff_value   = val;
      return r;
   endfunction

   function automatic logic signed [bqc_pkg::SAMPLE_WIDTH-1:0] rand_sample();
      int pick;
      pick = $urandom_range(0, 99);
      if (pick < 6) return SMP_MAX;
      if (pick < 12) return SMP_MIN;
      if (pick < 30) return SW'(int'($urandom_range(0, 4000)) - 2000);
      return SW'($urandom);
   endfunction

   // mostly tame coefficients so the cascade stays in range, some wild ones
   function automatic logic signed [bqc_pkg::COEFF_WIDTH-1:0] rand_coef(logic [2:0] ci);
      int pick;
      pick = $urandom_range(0, 99);
      if (pick < 8) return $urandom;
      if (pick < 12) return ($urandom_range(0, 1) == 1) ? CF_MAX : CF_MIN;
      if (pick < 30) return int'($urandom_range(0, 1 << 28)) - (1 << 27);
      if (ci == bqc_pkg::COEF_A2) return int'($urandom_range(0, 1 << 24)) - (1 << 23);
      return int'($urandom_range(0, 1 << 25)) - (1 << 24);
   endfunction

   function automatic bqc_pkg::req_type rand_item();
      bqc_pkg::req_type r;
      int               pick;
      r.sample_in     = rand_sample();
      r.section_index = 2'($urandom);
      r.coeff_index   = 3'($urandom);
      r.coeff_value   = $urandom;
      pick = $urandom_range(0, 99);
      if (pick < 82) begin
         r.action = bqc_pkg::ACT_FILTER;
      end else if (pick < 91) begin
         r.action      = bqc_pkg::ACT_WRITE;
         r.coeff_index = 3'($urandom_range(bqc_pkg::COEF_B0, bqc_pkg::COEF_A2));
         r.coeff_value = rand_coef(r.coeff_index);
      end else if (pick < 94) begin
         // any selector, out-of-range ones included, raw value
         r.action = bqc_pkg::ACT_WRITE;
      end else if (pick < 97) begin
         r.action = bqc_pkg::ACT_CLEAR;
      end else begin
         r.action = ACT_UNUSED;
      end
      return r;
   endfunction

   task automatic send_req(bqc_pkg::req_type r);
      int gap;
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 24);
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
         if (gap > 0) begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
      burst_left--;
      req       <= r;
      req_valid <= 1'b1;
      do @(posedge clock); while (req_stall);
   endtask

   task automatic write_sections(logic [2:0] v);
      csr_data  <= v;
      csr_valid <= 1'b1;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
   endtask

   // writes and clears leave no response, so drain a full cascade time after;
   // the first edge lets the monitor note the last accepted request
   task automatic wait_idle();
      req_valid <= 1'b0;
      burst_left = 0;
      @(posedge clock);
      while (sb.pending() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic run_directed();
      // one section, coefficients still zero
      send_req(mk(bqc_pkg::ACT_FILTER, SMP_MAX, 2'd0, bqc_pkg::COEF_B0, '0));
      send_req(mk(bqc_pkg::ACT_WRITE, '0, 2'd0, bqc_pkg::COEF_B0, CF_ONE));
      send_req(mk(bqc_pkg::ACT_FILTER, SMP_MAX, 2'd0, bqc_pkg::COEF_B0, '0));
      send_req(mk(bqc_pkg::ACT_FILTER, SMP_MIN, 2'd0, bqc_pkg::COEF_B0, '0));
      send_req(mk(bqc_pkg::ACT_WRITE, '0, 2'd0, bqc_pkg::COEF_A1, CF_MAX));
      send_req(mk(bqc_pkg::ACT_WRITE, '0, 2'd0, bqc_pkg::COEF_A2, CF_MIN));
      send_req(mk(bqc_pkg::ACT_WRITE, '0, 2'd0, bqc_pkg::COEF_B1, CF_MAX));
      send_req(mk(bqc_pkg::ACT_FILTER, SMP_MAX, 2'd0, bqc_pkg::COEF_B0, '0));
      send_req(mk(bqc_pkg::ACT_FILTER, SMP_MIN, 2'd0, bqc_pkg::COEF_B0, '0));
      send_req(mk(bqc_pkg::ACT_FILTER, '0, 2'd0, bqc_pkg::COEF_B0, '0));
      send_req(mk(ACT_UNUSED, SMP_MAX, 2'd0, bqc_pkg::COEF_B0, CF_MAX));
      // out-of-range selectors must not touch the store
      send_req(mk(bqc_pkg::ACT_WRITE, '0, 2'd0, COEF_BAD_LO, CF_MAX));
      send_req(mk(bqc_pkg::ACT_WRITE, '0, 2'd3, COEF_BAD_HI, CF_MIN));
      send_req(mk(bqc_pkg::ACT_CLEAR, '0, 2'd0, bqc_pkg::COEF_B0, '0));
      send_req(mk(bqc_pkg::ACT_FILTER, SMP_MIN, 2'd0, bqc_pkg::COEF_B0, '0));
      send_req(mk(bqc_pkg::ACT_WRITE, '0, 2'd0, bqc_pkg::COEF_B2, CF_MIN));
      send_req(mk(bqc_pkg::ACT_FILTER, '0, 2'd0, bqc_pkg::COEF_B0, '0));
      wait_idle();
      write_sections(3'd0);
      send_req(mk(bqc_pkg::ACT_FILTER, SMP_MAX, 2'd0, bqc_pkg::COEF_B0, '0));
      wait_idle();
      write_sections(3'd7);
      send_req(mk(bqc_pkg::ACT_WRITE, '0, 2'd1, bqc_pkg::COEF_B0, CF_ONE));
      send_req(mk(bqc_pkg::ACT_WRITE, '0, 2'd2, bqc_pkg::COEF_B0, CF_ONE));
      send_req(mk(bqc_pkg::ACT_WRITE, '0, 2'd3, bqc_pkg::COEF_A2, CF_MIN));
      send_req(mk(bqc_pkg::ACT_FILTER, SMP_MAX, 2'd0, bqc_pkg::COEF_B0, '0));
      send_req(mk(bqc_pkg::ACT_FILTER, SMP_MIN, 2'd0, bqc_pkg::COEF_B0, '0));
      send_req(mk(bqc_pkg::ACT_CLEAR, '0, 2'd0, bqc_pkg::COEF_B0, '0));
   endtask

   task automatic run_phase(logic [2:0] nsec, int count);
      wait_idle();
      write_sections(nsec);
      for (int s = 0; s < N_SEC; s++)
         for (int k = bqc_pkg::COEF_B0; k <= bqc_pkg::COEF_A2; k++)
            send_req(mk(bqc_pkg::ACT_WRITE, rand_sample(), s[1:0], k[2:0],
                        rand_coef(k[2:0])));
      send_req(mk(bqc_pkg::ACT_CLEAR, rand_sample(), 2'd0, bqc_pkg::COEF_B0, '0));
      repeat (count) send_req(rand_item());
   endtask

   initial begin
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      run_directed();
      foreach (phase_sec[i]) run_phase(phase_sec[i][2:0], 200);
      wait_idle();
      sb.finish_check();
      if (sb.errors == 0) begin
         $display("** biquad_cascade_iir_filter: PASSED **");
      end else begin
         $display("** biquad_cascade_iir_filter: FAILED **");
      end
      $finish;
   end

endmodule

/* biquad_cascade_iir_filter.f */
hdl/bqc_pkg.sv
hdl/biquad_cascade_iir_filter.sv
dv/tb.sv
